[rtl/core/dtok_pkg.sv]
// Package for the declaration tokenizer: token kinds, token record and
// the character codes that the lexer matches. No dependencies.
package dtok_pkg;

    typedef enum logic [3:0] {
        KIND_NUMBER   = 4'd0,
        KIND_VAR      = 4'd1,
        KIND_ARRAY    = 4'd2,
        KIND_OF       = 4'd3,
        KIND_NAME     = 4'd4,
        KIND_COLON    = 4'd5,
        KIND_SEMI     = 4'd6,
        KIND_RANGE    = 4'd7,
        KIND_COMMA    = 4'd8,
        KIND_LBRACKET = 4'd9,
        KIND_RBRACKET = 4'd10,
        KIND_END      = 4'd11,
        KIND_ERROR    = 4'd12
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [6:0]  length;
        logic        last;
    } token_t;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    localparam logic [15:0] START_MAX  = 16'hFFFF;
    localparam int          PREFIX_LEN = 5;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_Y      = 8'h79;

endpackage

[rtl/core/declaration_tokenizer.sv]
// Declaration tokenizer top level: lexer state, token decode and a
// three-entry token queue. Depends on dtok_pkg.
//
// Usage:
//   Slave side takes one beat per source byte: s_tdata is the byte and
//   s_tuser is the action (0 byte, 1 end of text). Master side gives one
//   beat per token: kind in m_tuser, start and length in m_tdata, and
//   m_tlast on the final token caused by one input beat.
//   A word, a number or a dot is reported when the byte that ends it
//   arrives, so one input beat yields zero, one or two tokens. End of
//   text flushes what is pending, emits an END token and clears the state.
//   A token is registered in the token queue before it appears on the
//   master side. Throughput: one input beat per cycle while m_tready is
//   high and each beat yields at most one token; a beat that yields two
//   tokens holds off the next beat until the single-token-per-beat
//   master port has drained the token queue to one token.
//   s_tready is high while the queue holds at most one token, so a stalled
//   receiver fills the queue and then holds off the sender; no token is
//   lost or repeated.
//   Reset clears the position counter, the open word, the pending dot and
//   the queue; the block is ready as soon as reset is released.
module declaration_tokenizer #(
    parameter int MAX_WORD       = 64,
    parameter int POSITION_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] token_start, [22:16] token_length, [23] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import dtok_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD);
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_START_MAX = POSITION_WIDTH'(START_MAX);

    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]          word_len_reg, word_len_next;
    logic [15:0]               word_start_reg, word_start_next;
    logic                      word_letter_reg, word_letter_next;
    logic                      word_over_reg, word_over_next;
    logic                      dot_reg, dot_next;
    logic [15:0]               dot_pos_reg, dot_pos_next;
    logic [7:0]                prefix_reg [PREFIX_LEN];

    token_t                    q_reg [3];
    token_t                    q_next [3];
    logic [1:0]                cnt_reg, cnt_next;

    logic        fire, pop;
    logic        is_end;
    logic [7:0]  ch;
    logic        is_letter, is_digit, is_alnum, is_blank, is_dot;
    logic [15:0] pos16;
    kind_t       word_kind, char_kind;
    logic        kw_var, kw_array, kw_of;
    logic        word_open;
    logic        push_a, push_b;
    token_t      tok_a, tok_b;
    logic [1:0]  base;

    assign fire     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= 2'd1);

    assign is_end    = (s_tuser[0] == ACTION_END);
    assign ch        = s_tdata;
    assign is_letter = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_alnum  = is_letter || is_digit;
    assign is_blank  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_dot    = (ch == CH_DOT);
    assign pos16     = (pos_reg > POS_START_MAX) ? START_MAX : 16'(pos_reg);
    assign word_open = (word_len_reg != '0);

    assign kw_var   = !word_over_reg && (word_len_reg == LEN_W'(3))
                      && (prefix_reg[0] == CH_V) && (prefix_reg[1] == CH_A)
                      && (prefix_reg[2] == CH_R);
    assign kw_array = !word_over_reg && (word_len_reg == LEN_W'(5))
                      && (prefix_reg[0] == CH_A) && (prefix_reg[1] == CH_R)
                      && (prefix_reg[2] == CH_R) && (prefix_reg[3] == CH_A)
                      && (prefix_reg[4] == CH_Y);
    assign kw_of    = !word_over_reg && (word_len_reg == LEN_W'(2))
                      && (prefix_reg[0] == CH_O) && (prefix_reg[1] == CH_F);

    always_comb
    begin
        if (!word_letter_reg)
            word_kind = KIND_NUMBER;
        else if (kw_var)
            word_kind = KIND_VAR;
        else if (kw_array)
            word_kind = KIND_ARRAY;
        else if (kw_of)
            word_kind = KIND_OF;
        else
            word_kind = KIND_NAME;
    end

    always_comb
    begin
        case (ch)
            CH_COLON:  char_kind = KIND_COLON;
            CH_SEMI:   char_kind = KIND_SEMI;
            CH_COMMA:  char_kind = KIND_COMMA;
            CH_LBRACK: char_kind = KIND_LBRACKET;
            CH_RBRACK: char_kind = KIND_RBRACKET;
            default:   char_kind = KIND_ERROR;
        endcase
    end

    // First token: pending dot or word flush; second: END or character token.
    always_comb
    begin
        push_a = 1'b0;
        push_b = 1'b0;
        tok_a  = '{kind: KIND_ERROR, start: dot_pos_reg, length: 7'd1, last: 1'b0};
        tok_b  = '{kind: char_kind, start: pos16, length: 7'd1, last: 1'b1};
        if (dot_reg)
        begin
            push_a = 1'b1;
            if (!is_end && is_dot)
            begin
                tok_a.kind   = KIND_RANGE;
                tok_a.length = 7'd2;
            end
        end
        else if (word_open && (is_end || !is_alnum))
        begin
            push_a       = 1'b1;
            tok_a.kind   = word_kind;
            tok_a.start  = word_start_reg;
            tok_a.length = 7'(word_len_reg);
        end
        if (is_end)
        begin
            push_b       = 1'b1;
            tok_b.kind   = KIND_END;
            tok_b.length = 7'd0;
        end
        else if (!(dot_reg && is_dot) && !is_alnum && !is_blank && !is_dot)
        begin
            push_b = 1'b1;
        end
        tok_a.last = !push_b;
    end

    always_comb
    begin
        pos_next         = pos_reg;
        word_len_next    = word_len_reg;
        word_start_next  = word_start_reg;
        word_letter_next = word_letter_reg;
        word_over_next   = word_over_reg;
        dot_next         = dot_reg;
        dot_pos_next     = dot_pos_reg;
        if (fire)
        begin
            if (is_end)
            begin
                pos_next         = '0;
                word_len_next    = '0;
                word_start_next  = '0;
                word_letter_next = 1'b0;
                word_over_next   = 1'b0;
                dot_next         = 1'b0;
                dot_pos_next     = '0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + 1'b1;
                dot_next = !dot_reg && is_dot;
                if (!dot_reg && is_dot)
                    dot_pos_next = pos16;
                if (is_alnum)
                begin
                    if (!word_open)
                        word_start_next = pos16;
                    if (is_letter)
                        word_letter_next = 1'b1;
                    if (word_len_reg < LEN_MAX)
                        word_len_next = word_len_reg + 1'b1;
                    else
                        word_over_next = 1'b1;
                end
                else
                begin
                    word_len_next    = '0;
                    word_start_next  = '0;
                    word_letter_next = 1'b0;
                    word_over_next   = 1'b0;
                end
            end
        end
    end

    // Shift the queue on pop, then append the new tokens behind what stays.
    always_comb
    begin
        base = cnt_reg - {1'b0, pop};
        for (int i = 0; i < 3; i++)
        begin
            if (pop && (i < 2))
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            if (fire && push_a && (base == 2'(i)))
                q_next[i] = tok_a;
            if (fire && push_b && ((base + {1'b0, push_a}) == 2'(i)))
                q_next[i] = tok_b;
        end
        cnt_next = base + (fire ? ({1'b0, push_a} + {1'b0, push_b}) : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            word_len_reg    <= '0;
            word_start_reg  <= '0;
            word_letter_reg <= 1'b0;
            word_over_reg   <= 1'b0;
            dot_reg         <= 1'b0;
            dot_pos_reg     <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            word_len_reg    <= word_len_next;
            word_start_reg  <= word_start_next;
            word_letter_reg <= word_letter_next;
            word_over_reg   <= word_over_next;
            dot_reg         <= dot_next;
            dot_pos_reg     <= dot_pos_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            q_reg[i] <= q_next[i];
        for (int i = 0; i < PREFIX_LEN; i++)
            if (fire && !is_end && is_alnum && (word_len_reg == LEN_W'(i)))
                prefix_reg[i] <= ch;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {1'b0, q_reg[0].length, q_reg[0].start};
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;

`ifndef NO_ASSERTIONS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_end |=> (pos_reg == '0) && (word_len_reg == '0) && !dot_reg)
        else $error("state not cleared after end of text");

    a_dot_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg |-> (word_len_reg == '0))
        else $error("dot pending while a word is open");

    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        word_over_reg |-> (word_len_reg == LEN_MAX))
        else $error("word overflow below maximum length");

    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_MAX) && fire && !is_end |=> (pos_reg == POS_MAX))
        else $error("position counter wrapped");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd3 |-> !s_tready)
        else $error("input taken while token queue full");
`endif

endmodule
